// ===== rtl/core/bblc_pkg.sv =====
// Package: shared types, constants and controller states for the byte-budget LRU cache core.
package bblc_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam logic [31:0] BUDGET_RST = 32'd1048576;

	typedef enum logic [1:0] {
		KIND_EVICT = 2'd0,
		KIND_HIT   = 2'd1,
		KIND_INS   = 2'd2,
		KIND_BIG   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_EVICT,
		ST_INSERT,
		ST_HIT,
		ST_BIG,
		ST_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture request, clear scan state
		logic scan;      // examine one slot
		logic evict;     // evict the oldest slot, post notice
		logic insert;    // insert the request, post final word
		logic hit;       // promote the hit slot, post final word
		logic big;       // post too-large final word
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done; // last slot examined this cycle
		logic found;     // a valid slot matched the key
		logic too_big;   // item_size > budget
		logic over;      // bytes_used + size > budget
		logic any_valid;
		logic full;
		logic out_busy;  // output register holds a stalled word
	} stat_t;

endpackage

// ===== rtl/core/byte_budget_lru_cache_core.sv =====
// Top level of the byte-budget LRU cache core.
// Flow: lookup walks all ENTRIES slots (one per cycle), then decides;
// each eviction posts a notice and rescans, then the final word is shown.
// Requests: one request at a time; a new one is taken only once the
// controller is back in idle.
// Reset: arst_n clears valid bits, byte count and control; budget to 1048576.
module byte_budget_lru_cache_core #(
	parameter int unsigned ENTRIES = bblc_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] req_key,
	input  logic [31:0] item_size,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] key_out,
	output logic [31:0] size_out,
	output logic        last
);

	bblc_pkg::cmd_t  cmd;
	bblc_pkg::stat_t st;
	logic            idle;

	// a request word is taken only while the controller is idle
	assign in_stall = !idle;
	assign cfg_ready = 1'b1;

	bblc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_valid && idle),
		.st(st), .cmd(cmd), .idle(idle)
	);

	bblc_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.req_key(req_key), .item_size(item_size),
		.cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .key_out(key_out), .size_out(size_out), .last(last)
	);

endmodule

// ===== rtl/core/bblc_ctrl.sv =====
// Controller state machine of the byte-budget LRU cache core.
module bblc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_go,
	input  bblc_pkg::stat_t   st,
	output bblc_pkg::cmd_t    cmd,
	output logic              idle
);

	bblc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bblc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bblc_pkg::ST_IDLE: if (in_go) state_d = bblc_pkg::ST_SCAN;
			bblc_pkg::ST_SCAN: if (st.scan_done) state_d = bblc_pkg::ST_DECIDE;
			bblc_pkg::ST_DECIDE: begin
				if (st.found) state_d = bblc_pkg::ST_HIT;
				else if (st.too_big) state_d = bblc_pkg::ST_BIG;
				else if (st.any_valid && (st.over || st.full)) state_d = bblc_pkg::ST_EVICT;
				else state_d = bblc_pkg::ST_INSERT;
			end
			// eviction rescans ranks, so go back through SCAN
			bblc_pkg::ST_EVICT: if (!st.out_busy) state_d = bblc_pkg::ST_SCAN;
			bblc_pkg::ST_INSERT,
			bblc_pkg::ST_HIT,
			bblc_pkg::ST_BIG: if (!st.out_busy) state_d = bblc_pkg::ST_OUT;
			bblc_pkg::ST_OUT: if (!st.out_busy) state_d = bblc_pkg::ST_IDLE;
			default: state_d = bblc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		case (state_q)
			bblc_pkg::ST_IDLE: begin
				idle = 1'b1;
				cmd.load = in_go;
			end
			bblc_pkg::ST_SCAN: cmd.scan = 1'b1;
			bblc_pkg::ST_EVICT: cmd.evict = !st.out_busy;
			bblc_pkg::ST_INSERT: cmd.insert = !st.out_busy;
			bblc_pkg::ST_HIT: cmd.hit = !st.out_busy;
			bblc_pkg::ST_BIG: cmd.big = !st.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/bblc_dp.sv =====
// Datapath of the byte-budget LRU cache core: entry store, scan unit, output register.
module bblc_dp #(
	parameter int unsigned ENTRIES = bblc_pkg::ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bblc_pkg::cmd_t   cmd,
	output bblc_pkg::stat_t  st,
	input  logic [31:0]      req_key,
	input  logic [31:0]      item_size,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       kind,
	output logic [31:0]      key_out,
	output logic [31:0]      size_out,
	output logic             last
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	// key/size/rank are arrays: key and size written at the free slot, read at the scan pointer and oldest slot
	logic [31:0]   keys_mem [ENTRIES];
	logic [31:0]   sizes_mem [ENTRIES];
	logic [IW-1:0] rank_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [31:0]   budget_q, used_q, key_q, size_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] ptr_q;
	logic          found_q, oldf_q, freef_q;
	logic [IW-1:0] hit_q, old_q, free_q, hrank_q, orank_q;
	logic [31:0]   hsize_q;

	logic [32:0] need;
	assign need = {1'b0, used_q} + {1'b0, size_q};

	assign st.scan_done = cmd.scan && (ptr_q == IW'(ENTRIES - 1));
	assign st.found     = found_q;
	assign st.too_big   = size_q > budget_q;
	assign st.over      = need > {1'b0, budget_q};
	assign st.any_valid = |valid_q;
	assign st.full      = cnt_q == CW'(ENTRIES);
	assign st.out_busy  = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= bblc_pkg::BUDGET_RST;
			used_q <= '0;
			cnt_q <= '0;
			valid_q <= '0;
			ptr_q <= '0;
			found_q <= 1'b0;
			oldf_q <= 1'b0;
			freef_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) budget_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.load) begin
				ptr_q <= '0;
				found_q <= 1'b0;
				oldf_q <= 1'b0;
				freef_q <= 1'b0;
			end
			if (cmd.scan) begin
				ptr_q <= (ptr_q == IW'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
				if (valid_q[ptr_q] && !found_q && keys_mem[ptr_q] == key_q) begin
					found_q <= 1'b1;
					hit_q <= ptr_q;
				end
				if (valid_q[ptr_q] && (!oldf_q || rank_mem[ptr_q] > orank_q)) begin
					oldf_q <= 1'b1;
					old_q <= ptr_q;
				end
				if (!valid_q[ptr_q] && !freef_q) begin
					freef_q <= 1'b1;
					free_q <= ptr_q;
				end
			end
			if (cmd.evict) begin
				valid_q[old_q] <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
				used_q <= used_q - sizes_mem[old_q];
				ptr_q <= '0;
				oldf_q <= 1'b0;
				freef_q <= 1'b0;
				out_valid <= 1'b1;
			end
			if (cmd.insert) begin
				valid_q[free_q] <= 1'b1;
				cnt_q <= cnt_q + 1'b1;
				used_q <= used_q + size_q;
				out_valid <= 1'b1;
			end
			if (cmd.hit || cmd.big) out_valid <= 1'b1;
		end
	end

	// Payload registers and the store.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= req_key;
			size_q <= item_size;
		end
		if (cmd.scan) begin
			if (valid_q[ptr_q] && (!oldf_q || rank_mem[ptr_q] > orank_q))
				orank_q <= rank_mem[ptr_q];
			if (valid_q[ptr_q] && !found_q && keys_mem[ptr_q] == key_q) begin
				hrank_q <= rank_mem[ptr_q];
				hsize_q <= sizes_mem[ptr_q];
			end
		end
		if (cmd.evict) begin
			kind <= bblc_pkg::KIND_EVICT;
			key_out <= keys_mem[old_q];
			size_out <= sizes_mem[old_q];
			last <= 1'b0;
		end
		if (cmd.insert) begin
			kind <= bblc_pkg::KIND_INS;
			key_out <= key_q;
			size_out <= size_q;
			last <= 1'b1;
			keys_mem[free_q] <= key_q;
			sizes_mem[free_q] <= size_q;
		end
		if (cmd.hit) begin
			kind <= bblc_pkg::KIND_HIT;
			key_out <= key_q;
			size_out <= hsize_q;
			last <= 1'b1;
		end
		if (cmd.big) begin
			kind <= bblc_pkg::KIND_BIG;
			key_out <= key_q;
			size_out <= size_q;
			last <= 1'b1;
		end
		// rank update, all entries at once (each is its own register)
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.insert) begin
				if (IW'(i) == free_q) rank_mem[i] <= '0;
				else if (valid_q[i]) rank_mem[i] <= rank_mem[i] + 1'b1;
			end
			if (cmd.hit) begin
				if (IW'(i) == hit_q) rank_mem[i] <= '0;
				else if (valid_q[i] && rank_mem[i] < hrank_q) rank_mem[i] <= rank_mem[i] + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/bblc_chk.sv =====
// Port-level checker for the byte-budget LRU cache core, with its bind.
module bblc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic        last
);

	// an accepted request blocks the next one until its final word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("request accepted back to back");

	// notices are never final, other kinds always are
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind != bblc_pkg::KIND_EVICT))) else $error("last flag wrong");

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
		else $error("output changed under stall");

endmodule

bind byte_budget_lru_cache_core bblc_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind), .last(last)
);

// ===== tb/tb.sv =====
// Testbench for the byte-budget LRU cache core: directed table plus random traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = bblc_pkg::ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 8 * (NSLOT + 4);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] req_key = '0;
	logic [31:0] item_size = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [31:0] key_out;
	logic [31:0] size_out;
	logic last;

	always #5 clk = ~clk;

	byte_budget_lru_cache_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_key(req_key), .item_size(item_size),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .key_out(key_out), .size_out(size_out), .last(last)
	);

	// One result word as the cache reports it.
	typedef struct packed {
		bblc_pkg::kind_t k;
		logic [31:0]     key;
		logic [31:0]     size;
		logic            fin;
	} word_t;

	// Predictor's own copy of the cache.
	logic [31:0] budget_m;
	logic [31:0] keys_m  [NSLOT];
	logic [31:0] sizes_m [NSLOT];
	logic        valid_m [NSLOT];
	int unsigned rank_m  [NSLOT];
	logic [31:0] used_m;

	word_t pending_words[$];
	int    n_errors = 0;
	int    n_words = 0;
	int    n_evicts = 0;
	int    n_hits = 0;
	int    n_big = 0;
	int    cycles = 0;
	int    long_left = 0;      // remaining cycles of a long receiver stall
	bit    hold_off = 1'b0;    // long receiver stall for back-pressure

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display({"MISMATCH %s at %0t: got k=%0d key=%h size=%h last=%b,",
			" want k=%0d key=%h size=%h last=%b"},
			what, $realtime, got.k, got.key, got.size, got.fin,
			want.k, want.key, want.size, want.fin);
		n_errors++;
	endtask

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < NSLOT; i++)
			if (valid_m[i]) n++;
		return n;
	endfunction

	// Drop the least-recent entry and queue its eviction notice.
	function automatic void evict_lru();
		int s;
		word_t w;
		s = -1;
		for (int i = 0; i < NSLOT; i++)
			if (valid_m[i] && (s < 0 || rank_m[i] > rank_m[s])) s = i;
		if (s < 0) return;
		w = '{bblc_pkg::KIND_EVICT, keys_m[s], sizes_m[s], 1'b0};
		pending_words.push_back(w);
		used_m -= sizes_m[s];
		valid_m[s] = 1'b0;
	endfunction

	// Apply one request to the predictor and queue every word it causes.
	function automatic void predict_request(input logic [31:0] k, input logic [31:0] sz);
		int hit;
		int slot;
		word_t w;
		hit = -1;
		slot = -1;
		for (int i = 0; i < NSLOT && hit < 0; i++)
			if (valid_m[i] && keys_m[i] == k) hit = i;
		if (hit >= 0) begin
			for (int i = 0; i < NSLOT; i++)
				if (valid_m[i] && rank_m[i] < rank_m[hit]) rank_m[i]++;
			rank_m[hit] = 0;
			w = '{bblc_pkg::KIND_HIT, k, sizes_m[hit], 1'b1};
			pending_words.push_back(w);
			return;
		end
		if (sz > budget_m) begin
			w = '{bblc_pkg::KIND_BIG, k, sz, 1'b1};
			pending_words.push_back(w);
			return;
		end
		// 33-bit sum so the budget compare is exact
		while (({1'b0, used_m} + {1'b0, sz}) > {1'b0, budget_m} && live_count() > 0)
			evict_lru();
		if (live_count() >= NSLOT) evict_lru();
		for (int i = 0; i < NSLOT && slot < 0; i++)
			if (!valid_m[i]) slot = i;
		for (int i = 0; i < NSLOT; i++)
			if (valid_m[i]) rank_m[i]++;
		valid_m[slot] = 1'b1;
		keys_m[slot] = k;
		sizes_m[slot] = sz;
		rank_m[slot] = 0;
		used_m += sz;
		w = '{bblc_pkg::KIND_INS, k, sz, 1'b1};
		pending_words.push_back(w);
	endfunction

	// Output side: check each accepted word against the oldest expectation.
	always @(posedge clk) begin
		word_t got;
		word_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{bblc_pkg::kind_t'(kind), key_out, size_out, last};
			n_words++;
			if (kind == bblc_pkg::KIND_EVICT) n_evicts++;
			if (kind == bblc_pkg::KIND_HIT) n_hits++;
			if (kind == bblc_pkg::KIND_BIG) n_big++;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", got, got);
			end else begin
				want = pending_words.pop_front();
				if (got.k != want.k) report_mismatch("kind", got, want);
				else if (got.key != want.key) report_mismatch("key_out", got, want);
				else if (got.size != want.size) report_mismatch("size_out", got, want);
				else if (got.fin != want.fin) report_mismatch("last", got, want);
			end
		end
	end

	// Receiver stall pattern, driven at the falling edge: mostly short, a few long.
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_off) out_stall <= 1'b1;
		else if (long_left > 0) begin
			out_stall <= 1'b1;
			long_left--;
		end else if (r < 2) begin
			out_stall <= 1'b1;
			long_left = $urandom_range(10, 40);
		end else if (r < 60) out_stall <= 1'b0;
		else if (r < 97) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 1) == 1);
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycles, pending_words.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sender gap: mostly short, sometimes long.
	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		repeat (g) @(negedge clk);
	endtask

	// Offer one request word and hold it until accepted.
	task automatic send_request(input logic [31:0] k, input logic [31:0] sz);
		in_valid = 1'b1;
		req_key = k;
		item_size = sz;
		do @(posedge clk); while (in_stall);
		predict_request(k, sz);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Budget write, only with the cache drained and settled.
	task automatic write_budget(input logic [31:0] v);
		wait (pending_words.size() == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		budget_m = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Directed rows: key, size, and a typed expectation for the final word where obvious.
	typedef struct {
		logic [31:0]     k;
		logic [31:0]     sz;
		bit              typed;
		bblc_pkg::kind_t want_kind;
	} row_t;

	row_t plan [11] = '{
		'{32'h0000_0000, 32'd0,          1'b1, bblc_pkg::KIND_INS},  // zero size, empty cache
		'{32'hFFFF_FFFF, 32'd1048576,    1'b0, bblc_pkg::KIND_INS},  // exactly the budget
		'{32'h0000_0001, 32'd1048577,    1'b1, bblc_pkg::KIND_BIG},  // one past the budget
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1, bblc_pkg::KIND_HIT},  // hit ignores size
		'{32'h1234_5678, 32'hFFFF_FFFF,  1'b1, bblc_pkg::KIND_BIG},
		'{32'h0000_0010, 32'd100,        1'b0, bblc_pkg::KIND_INS},  // over budget, evicts
		'{32'h0000_0011, 32'd200,        1'b0, bblc_pkg::KIND_INS},
		'{32'h0000_0010, 32'd0,          1'b1, bblc_pkg::KIND_HIT},
		'{32'hAAAA_AAAA, 32'h5555_5555,  1'b1, bblc_pkg::KIND_BIG},
		'{32'h5555_5555, 32'd524288,     1'b0, bblc_pkg::KIND_INS},
		'{32'hAAAA_AAAA, 32'd524288,     1'b0, bblc_pkg::KIND_INS}
	};

	initial begin
		word_t snap;
		logic [31:0] k;
		logic [31:0] sz;
		int r;
		int cnt;

		budget_m = bblc_pkg::BUDGET_RST;
		used_m = '0;
		for (int i = 0; i < NSLOT; i++) begin
			valid_m[i] = 1'b0;
			keys_m[i] = '0;
			sizes_m[i] = '0;
			rank_m[i] = 0;
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset budget.
		foreach (plan[i]) begin
			send_request(plan[i].k, plan[i].sz);
			if (plan[i].typed) begin
				snap = pending_words[pending_words.size() - 1];
				if (snap.k != plan[i].want_kind)
					report_mismatch("directed row", snap, '{plan[i].want_kind, plan[i].k,
						plan[i].sz, 1'b1});
			end
			sender_gap();
		end

		// Send NSLOT+2 tiny items: they fill all sixteen slots, and the extra ones force slot evictions.
		for (int i = 0; i < NSLOT + 2; i++) send_request(32'h100 + i, 32'd1);

		// Budget extremes: zero lets only zero-size items in; lowered budget evicts.
		write_budget(32'd0);
		send_request(32'h200, 32'd0);
		send_request(32'h201, 32'd1);
		write_budget(32'hFFFF_FFFF);
		send_request(32'h300, 32'hFFFF_FFFF);
		send_request(32'h301, 32'd1);
		send_request(32'h300, 32'd7);
		write_budget(32'd1000);

		// Back-pressure: receiver holds off while the sender keeps going.
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) send_request(32'h400 + i, 32'd400);
		join

		// Random part: small key pool for hits, sizes near the budget for evictions.
		for (int n = 0; n < 120; n++) begin
			if (n == 40) write_budget($urandom_range(1, 4000));
			if (n == 80) write_budget(32'd5000);
			r = $urandom_range(0, 99);
			if (r < 70) k = $urandom_range(0, 23);
			else k = $urandom();
			cnt = $urandom_range(0, 99);
			if (cnt < 70) sz = $urandom_range(0, budget_m > 600 ? 600 : budget_m);
			else if (cnt < 85) sz = $urandom_range(0, budget_m);
			else sz = $urandom();
			send_request(k, sz);
			sender_gap();
		end

		wait (pending_words.size() == 0);
		repeat (SETTLE) @(negedge clk);
		$display("covered %0d result words: %0d evictions, %0d hits, %0d oversize misses",
			n_words, n_evicts, n_hits, n_big);
		$display("budget swept over zero, full range and small values, with a long output stall");
		if (n_errors == 0 && pending_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
